// ===== hdl/cfm_pkg.sv =====
`default_nettype none
package cfm_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int N_SPACE    = 9;
  localparam int N_MARK     = 5;
  localparam int CELLS      = 8;
  localparam int CELL_IDX_W = $clog2(CELLS);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LEN   = 1'd1;

  localparam logic [7:0] SYNC_RESET     = 8'h3C;
  localparam logic [7:0] NAME_LEN_RESET = 8'd18;

  localparam logic [COUNT_W-1:0] COUNT_MARK  = 4'd5;
  localparam logic [COUNT_W-1:0] COUNT_SPACE = 4'd9;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // 1200 Hz space cell and 2400 Hz mark cell, unsigned 8-bit sine
  localparam sample_t SPACE_TAB [N_SPACE] = '{
    8'h80, 8'hda, 8'hff, 8'hda, 8'h80, 8'h25, 8'h00, 8'h25, 8'h80
  };
  localparam sample_t MARK_TAB [N_MARK] = '{8'h80, 8'hff, 8'h80, 8'h00, 8'h80};

  typedef enum logic [1:0] {
    PH_SEEK = 2'd0,
    PH_NAME = 2'd1,
    PH_BODY = 2'd2
  } tape_phase_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       leader;
  } q_entry_t;

  typedef struct packed {
    logic [N_SPACE-1:0][SAMPLE_W-1:0] samples;
    logic [COUNT_W-1:0]               count;
    logic                             last_cell;
    logic                             leader_due;
  } cell_t;

  function automatic cell_t make_cell(input logic mark, input logic last,
                                      input logic leader);
    cell_t c;
    for (int j = 0; j < N_SPACE; j++) begin
      if (mark) begin
        c.samples[j] = (j < N_MARK) ? MARK_TAB[j] : '0;
      end else begin
        c.samples[j] = SPACE_TAB[j];
      end
    end
    c.count      = mark ? COUNT_MARK : COUNT_SPACE;
    c.last_cell  = last;
    c.leader_due = last & leader;
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cfm_if.sv =====
`default_nettype none
interface cfm_byte_if;
  import cfm_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface cfm_cell_if;
  import cfm_pkg::*;
  logic               valid;
  logic               ready;
  sample_t            sample_0;
  sample_t            sample_1;
  sample_t            sample_2;
  sample_t            sample_3;
  sample_t            sample_4;
  sample_t            sample_5;
  sample_t            sample_6;
  sample_t            sample_7;
  sample_t            sample_8;
  logic [COUNT_W-1:0] sample_count;
  logic               last_cell;
  logic               leader_due;
  modport source (output valid, output sample_0, output sample_1, output sample_2,
                  output sample_3, output sample_4, output sample_5, output sample_6,
                  output sample_7, output sample_8, output sample_count,
                  output last_cell, output leader_due, input ready);
  modport sink   (input valid, input sample_0, input sample_1, input sample_2,
                  input sample_3, input sample_4, input sample_5, input sample_6,
                  input sample_7, input sample_8, input sample_count,
                  input last_cell, input leader_due, output ready);
endinterface
`default_nettype wire

// ===== hdl/cassette_fsk_byte_modulator.sv =====
// Cassette FSK byte modulator.
// in_byte: valid/ready channel of tape bytes. out_cell: valid/ready channel
// of bit cells, eight per byte, least significant bit first; a one bit gives
// the five-sample 2400 Hz cell, a zero bit the nine-sample 1200 Hz cell.
// cfg_we/cfg_index/cfg_data write the sync byte (index 0) and the name
// record length (index 1); write them only while the block is idle.
// The front end follows the tape layout (sync hunt, name record, body) as
// each byte is accepted and tags it; a two-entry queue holds tagged bytes
// for the back end, which emits one cell per cycle into an output register
// while cells are taken and a byte waits. A byte is held in a queue entry,
// then its cells in the output register, stepped by the back end's counter;
// the queue lets the next bytes be accepted while cells drain.
// When out_cell.ready is low the current cell holds and the back end
// stops; in_byte.ready drops once the queue is full.
// Reset (rst_n low, synchronous) empties the queue, clears the output,
// returns to the sync hunt and restores the register defaults.
`default_nettype none
module cassette_fsk_byte_modulator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  cfm_byte_if.sink                            in_byte,
  cfm_cell_if.source                          out_cell,
  input  wire logic                           cfg_we,
  input  wire logic [cfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cfm_pkg::*;

  logic     q_ready;
  logic     q_push;
  q_entry_t q_entry;
  logic     head_valid;
  q_entry_t head_entry;
  logic     pop;

  cfm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  cfm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .push_ready (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  cfm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_cell   (out_cell)
  );

endmodule
`default_nettype wire

// ===== hdl/cfm_front.sv =====
`default_nettype none
module cfm_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  cfm_byte_if.sink                          in_byte,
  input  wire logic                         cfg_we,
  input  wire logic [cfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                         q_ready,
  output      logic                         q_push,
  output      cfm_pkg::q_entry_t            q_entry
);
  import cfm_pkg::*;

  logic [7:0]  sync_value_r;
  logic [7:0]  name_len_r;
  tape_phase_t phase_r, phase_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        leader;
  logic        is_sync;
  logic [7:0]  left_dec;

  assign in_byte.ready = q_ready;
  assign q_push        = in_byte.valid & q_ready;
  assign is_sync       = (in_byte.data_byte == sync_value_r);
  assign left_dec      = left_r - 8'd1;

  // next tape phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_SEEK: begin
        if (is_sync) phase_nxt = (name_len_r == '0) ? PH_BODY : PH_NAME;
      end
      PH_NAME: begin
        if (left_dec == '0) phase_nxt = PH_BODY;
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // leader flag and name byte count
  always_comb begin
    leader   = 1'b0;
    left_nxt = left_r;
    case (phase_r)
      PH_SEEK: begin
        if (is_sync) begin
          leader   = (name_len_r == '0);
          left_nxt = name_len_r;
        end
      end
      PH_NAME: begin
        left_nxt = left_dec;
        leader   = (left_dec == '0);
      end
      default: leader = 1'b0;
    endcase
  end

  assign q_entry.data_byte = in_byte.data_byte;
  assign q_entry.leader    = leader;

  // advance tape state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      left_r  <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r <= SYNC_RESET;
      name_len_r   <= NAME_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_VALUE: sync_value_r <= cfg_data;
        CFG_NAME_LEN:   name_len_r   <= cfg_data;
        default:        ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cfm_queue.sv =====
`default_nettype none
module cfm_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cfm_pkg::q_entry_t push_entry,
  output      logic              push_ready,
  input  wire logic              pop,
  output      logic              head_valid,
  output      cfm_pkg::q_entry_t head_entry
);
  import cfm_pkg::*;

  localparam int DEPTH = 2;

  q_entry_t   mem_r [DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt_r != 2'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & head_valid;

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

  // move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cfm_back.sv =====
`default_nettype none
module cfm_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire cfm_pkg::q_entry_t head_entry,
  output      logic              pop,
  cfm_cell_if.source             out_cell
);
  import cfm_pkg::*;

  logic [CELL_IDX_W-1:0] idx_r;
  logic                  out_valid_r;
  cell_t                 cell_r, cell_nxt;
  logic                  adv;
  logic                  is_last;

  assign adv      = head_valid & (~out_valid_r | out_cell.ready);
  assign is_last  = (idx_r == CELL_IDX_W'(CELLS - 1));
  assign pop      = adv & is_last;
  assign cell_nxt = make_cell(head_entry.data_byte[idx_r], is_last, head_entry.leader);

  // step through the cells of the head item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      idx_r       <= idx_r + 1'b1;
      out_valid_r <= 1'b1;
    end else if (out_cell.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the cell until taken
  always_ff @(posedge clk) begin
    if (adv) cell_r <= cell_nxt;
  end

  assign out_cell.valid        = out_valid_r;
  assign out_cell.sample_0     = cell_r.samples[0];
  assign out_cell.sample_1     = cell_r.samples[1];
  assign out_cell.sample_2     = cell_r.samples[2];
  assign out_cell.sample_3     = cell_r.samples[3];
  assign out_cell.sample_4     = cell_r.samples[4];
  assign out_cell.sample_5     = cell_r.samples[5];
  assign out_cell.sample_6     = cell_r.samples[6];
  assign out_cell.sample_7     = cell_r.samples[7];
  assign out_cell.sample_8     = cell_r.samples[8];
  assign out_cell.sample_count = cell_r.count;
  assign out_cell.last_cell    = cell_r.last_cell;
  assign out_cell.leader_due   = cell_r.leader_due;

endmodule
`default_nettype wire

// ===== hdl/cfm_checker.sv =====
`default_nettype none
module cfm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_sample_5,
  input wire logic [7:0] out_sample_6,
  input wire logic [7:0] out_sample_7,
  input wire logic [7:0] out_sample_8,
  input wire logic [3:0] out_sample_count,
  input wire logic       out_last_cell,
  input wire logic       out_leader_due
);
  import cfm_pkg::*;

  // a stalled cell holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_count)
      && $stable(out_last_cell) && $stable(out_leader_due))
    else $error("stalled cell changed");

  // only mark or space cells appear
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_count == COUNT_MARK || out_sample_count == COUNT_SPACE))
    else $error("bad sample count");

  // leader request only on the last cell of a byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_leader_due |-> out_last_cell)
    else $error("leader_due off the last cell");

  // mark cells leave the tail samples at zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_count == COUNT_MARK |->
      out_sample_5 == '0 && out_sample_6 == '0 && out_sample_7 == '0
      && out_sample_8 == '0)
    else $error("mark cell tail not zero");

  // consecutive taken cells cannot both be last cells
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_cell ##1 out_valid |-> !out_last_cell)
    else $error("two last cells in a row");

endmodule

bind cassette_fsk_byte_modulator cfm_checker u_cfm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_cell.valid),
  .out_ready        (out_cell.ready),
  .out_sample_5     (out_cell.sample_5),
  .out_sample_6     (out_cell.sample_6),
  .out_sample_7     (out_cell.sample_7),
  .out_sample_8     (out_cell.sample_8),
  .out_sample_count (out_cell.sample_count),
  .out_last_cell    (out_cell.last_cell),
  .out_leader_due   (out_cell.leader_due)
);
`default_nettype wire

// ===== tb/tb_cassette_fsk_byte_modulator.sv =====
module tb_cassette_fsk_byte_modulator;
  timeunit 1ns;
  timeprecision 1ps;
  import cfm_pkg::*;

  localparam int TOTAL_BYTES = 150;
  localparam int MAX_WAIT    = 18;

  // one bit cell as seen on the output channel
  typedef struct {
    sample_t            smp [9];
    logic [COUNT_W-1:0] count;
    logic               last;
    logic               leader;
  } fsk_cell_t;

  // Tracks the tape layout and keys each accepted byte into its eight cells
  class cell_keyer;
    localparam sample_t SPACE_WAVE [9] = '{
      8'h80, 8'hda, 8'hff, 8'hda, 8'h80, 8'h25, 8'h00, 8'h25, 8'h80
    };
    localparam sample_t MARK_WAVE [5] = '{8'h80, 8'hff, 8'h80, 8'h00, 8'h80};
    localparam logic [COUNT_W-1:0] MARK_LEN  = 4'd5;
    localparam logic [COUNT_W-1:0] SPACE_LEN = 4'd9;

    logic [7:0]  hunt_val;
    logic [7:0]  name_len;
    tape_phase_t phase;
    logic [7:0]  name_left;
    fsk_cell_t   cells_due [$];
    int          errors;

    function new();
      hunt_val  = 8'h3C;
      name_len  = 8'd18;
      phase     = PH_SEEK;
      name_left = 8'd0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_SYNC_VALUE: hunt_val = val;
        CFG_NAME_LEN:   name_len = val;
        default: ;
      endcase
    endfunction

    function int due();
      return cells_due.size();
    endfunction

    // Advance the layout tracker, then queue the byte's cells, LSB first
    function void take_byte(logic [7:0] b);
      logic      leader;
      logic      mark;
      fsk_cell_t c;
      leader = 1'b0;
      case (phase)
        PH_SEEK: begin
          if (b == hunt_val) begin
            if (name_len == 8'd0) begin
              leader    = 1'b1;
              phase     = PH_BODY;
              name_left = 8'd0;
            end else begin
              phase     = PH_NAME;
              name_left = name_len;
            end
          end
        end
        PH_NAME: begin
          name_left = name_left - 8'd1;
          if (name_left == 8'd0) begin
            leader = 1'b1;
            phase  = PH_BODY;
          end
        end
        default: ;
      endcase
      for (int k = 0; k < 8; k++) begin
        mark = b[k];
        for (int j = 0; j < 9; j++) begin
          if (mark) begin
            c.smp[j] = (j < 5) ? MARK_WAVE[j] : 8'h00;
          end else begin
            c.smp[j] = SPACE_WAVE[j];
          end
        end
        c.count  = mark ? MARK_LEN : SPACE_LEN;
        c.last   = (k == 7);
        c.leader = (k == 7) && leader;
        cells_due.push_back(c);
      end
    endfunction

    function void note_diff(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %02h actual %02h", $time, field, want, got);
        errors++;
      end
    endfunction

    // Compare a delivered cell against the oldest pending one
    function void check_cell(fsk_cell_t got);
      fsk_cell_t want;
      if (cells_due.size() == 0) begin
        $display("%0t ns: cell with none pending, expected nothing actual count %0d",
                 $time, got.count);
        errors++;
        return;
      end
      want = cells_due.pop_front();
      for (int j = 0; j < 9; j++) begin
        note_diff($sformatf("sample_%0d", j), want.smp[j], got.smp[j]);
      end
      note_diff("sample_count", {4'd0, want.count}, {4'd0, got.count});
      note_diff("last_cell", {7'd0, want.last}, {7'd0, got.last});
      note_diff("leader_due", {7'd0, want.leader}, {7'd0, got.leader});
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfm_byte_if byte_ch ();
  cfm_cell_if cell_ch ();

  cell_keyer keyer = new();

  int sent;
  bit send_calm;
  bit recv_calm;

  cassette_fsk_byte_modulator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (byte_ch),
    .out_cell  (cell_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Watch both handshakes
  always @(posedge clk) begin
    fsk_cell_t got;
    if (rst_n) begin
      if (byte_ch.valid && byte_ch.ready) begin
        keyer.take_byte(byte_ch.data_byte);
      end
      if (cell_ch.valid && cell_ch.ready) begin
        got.smp[0] = cell_ch.sample_0;
        got.smp[1] = cell_ch.sample_1;
        got.smp[2] = cell_ch.sample_2;
        got.smp[3] = cell_ch.sample_3;
        got.smp[4] = cell_ch.sample_4;
        got.smp[5] = cell_ch.sample_5;
        got.smp[6] = cell_ch.sample_6;
        got.smp[7] = cell_ch.sample_7;
        got.smp[8] = cell_ch.sample_8;
        got.count  = cell_ch.sample_count;
        got.last   = cell_ch.last_cell;
        got.leader = cell_ch.leader_due;
        keyer.check_cell(got);
      end
    end
  end

  // Draw a wait, with occasional stretches of back-to-back traffic
  function automatic int pick_wait(ref bit calm);
    if ($urandom_range(0, 15) == 0) begin
      calm = ~calm;
    end
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Sink side: stall at random, then take one cell
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_wait(recv_calm);
      if (stall > 0) begin
        cell_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cell_ch.ready <= 1'b1;
      @(posedge clk);
      while (!cell_ch.valid) @(posedge clk);
    end
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = pick_wait(send_calm);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Drop valid and wait until every pending cell has come out
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (keyer.due() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    keyer.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [7:0] sync_pick;
    logic [7:0] len_pick;
    logic [7:0] b;
    int noise;
    int first_half;
    int next_write;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    cell_ch.ready     = 1'b0;
    sent              = 0;
    send_calm         = 1'b0;
    recv_calm         = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: hunt with extreme register values, none of these bytes match
    write_reg(CFG_SYNC_VALUE, 8'hFF);
    write_reg(CFG_NAME_LEN, 8'hFF);
    send_byte(8'h00);
    send_byte(8'h3C);
    send_byte(8'hFE);
    send_byte(8'h7F);
    drain();
    write_reg(CFG_SYNC_VALUE, 8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'hAA);
    send_byte(8'h55);
    drain();

    // Random tape: noise, sync, name record, then body
    sync_pick = pick_reg_value();
    len_pick  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 24));
    write_reg(CFG_SYNC_VALUE, sync_pick);
    write_reg(CFG_NAME_LEN, len_pick);
    noise = $urandom_range(5, 15);
    repeat (noise) begin
      do begin
        b = 8'($urandom_range(0, 255));
      end while (b == sync_pick);
      send_byte(b);
    end
    send_byte(sync_pick);

    // Rewrite both registers halfway; the record in progress keeps its count
    first_half = len_pick / 2;
    repeat (first_half) send_byte(8'($urandom_range(0, 255)));
    drain();
    write_reg(CFG_NAME_LEN, pick_reg_value());
    write_reg(CFG_SYNC_VALUE, pick_reg_value());
    repeat (int'(len_pick) - first_half) send_byte(8'($urandom_range(0, 255)));

    next_write = sent + $urandom_range(15, 30);
    while (sent < TOTAL_BYTES) begin
      send_byte(8'($urandom_range(0, 255)));
      if (sent >= next_write) begin
        drain();
        write_reg(CFG_SYNC_VALUE, pick_reg_value());
        write_reg(CFG_NAME_LEN, pick_reg_value());
        next_write = sent + $urandom_range(15, 30);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (keyer.errors == 0 && keyer.due() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
